[hdl/utf8d_pkg.sv]
// Shared types, constants and decode helpers for the UTF-8 decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int CpW    = 21;
    localparam int ByteW  = 8;
    localparam int MaxRes = 3;
    localparam int CntW   = 2;
    localparam int LenW   = 3;

    localparam logic [LenW-1:0] LEN_NONE = 3'd0;
    localparam logic [LenW-1:0] LEN_2    = 3'd2;
    localparam logic [LenW-1:0] LEN_3    = 3'd3;
    localparam logic [LenW-1:0] LEN_4    = 3'd4;

    localparam logic [CpW-1:0]   SUB_RESET = 21'd65533;
    localparam logic [ByteW-1:0] LEAD_MASK = 8'h7F;
    localparam logic [ByteW-1:0] TAIL_MASK = 8'h3F;
    localparam int               TAIL_BITS = 6;

    typedef logic [CpW-1:0] t_cp;

    typedef struct packed {
        t_cp  cp;
        logic repl;
        logic eqs;
        logic last;
        logic srv;
        logic cli;
    } t_result;

    typedef struct packed {
        logic [CntW-1:0]          cnt;
        t_result [MaxRes-1:0]     res;
    } t_bundle;

    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] data;
        logic             last;
    } t_in_beat;

    function automatic logic [LenW-1:0] seq_len(input logic [ByteW-1:0] b);
        logic [LenW-1:0] len;
        if (b[7:5] == 3'b110) begin
            len = LEN_2;
        end else if (b[7:4] == 4'b1110) begin
            len = LEN_3;
        end else if (b[7:3] == 5'b11110) begin
            len = LEN_4;
        end else begin
            len = LEN_NONE;
        end
        return len;
    endfunction

    function automatic t_result value_res(input t_cp v, input t_cp sub);
        t_result r;
        r      = '0;
        r.cp   = v;
        r.eqs  = (v == sub);
        return r;
    endfunction

    function automatic t_result subst_res(input t_cp sub);
        t_result r;
        r      = '0;
        r.cp   = sub;
        r.repl = 1'b1;
        return r;
    endfunction

    // A lone byte with nothing after it: plain ASCII decodes, anything else is replaced.
    function automatic t_result single_res(input logic [ByteW-1:0] b, input t_cp sub);
        t_result r;
        if (!b[7]) begin
            r = value_res({{(CpW-ByteW){1'b0}}, b}, sub);
        end else begin
            r = subst_res(sub);
        end
        return r;
    endfunction

endpackage

[hdl/utf8d_in_reg.sv]
// Input register stage that captures one byte beat from the slave stream.
`timescale 1ns / 1ps

module utf8d_in_reg
    import utf8d_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [ByteW-1:0] i_data,
    input  logic             i_last,
    input  logic             i_take,
    output t_in_beat         o_beat
);

    logic             r_valid;
    logic [ByteW-1:0] r_data;
    logic             r_last;
    logic             n_valid;

    // No beat is taken while reset is held, since it would be dropped.
    assign o_ready = i_rst_n && (!r_valid || i_take);

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
            r_last <= i_last;
        end
    end

    assign o_beat = '{valid: r_valid, data: r_data, last: r_last};

endmodule

[hdl/utf8d_decode.sv]
// Sequence state, substitute register and the per-byte decode into a result bundle.
`timescale 1ns / 1ps

module utf8d_decode
    import utf8d_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [CpW-1:0] i_cfg_data,
    input  t_in_beat       i_beat,
    input  logic           i_take,
    output t_bundle        o_bundle
);

    logic             fire;
    logic [CpW-1:0]   r_sub;
    logic [LenW-1:0]  r_needed;
    logic [CntW-1:0]  r_held_cnt;
    logic [ByteW-1:0] r_held0;
    t_cp              r_partial;
    logic             r_sticky_srv;
    logic             r_sticky_cli;

    logic [LenW-1:0]  n_needed;
    logic [CntW-1:0]  n_held_cnt;
    logic [ByteW-1:0] n_held0;
    t_cp              n_partial;
    logic             n_sticky_srv;
    logic             n_sticky_cli;

    t_cp              shifted;
    logic [LenW-1:0]  len_b;
    logic [LenW-1:0]  len_h;
    logic [ByteW-1:0] b;
    logic             any_repl;
    logic             any_eqs;
    t_bundle          bnd;

    assign fire        = i_beat.valid && i_take;
    // A write during reset would be lost, so the channel is held off then.
    assign o_cfg_ready = i_rst_n;
    assign b           = i_beat.data;
    assign len_b       = seq_len(b);
    assign len_h       = seq_len(r_held0);
    assign shifted     = CpW'({r_partial, b[TAIL_BITS-1:0]});

    always_comb begin
        bnd        = '0;
        n_needed   = r_needed;
        n_held_cnt = r_held_cnt;
        n_held0    = r_held0;
        n_partial  = r_partial;
        if (r_needed == LEN_NONE) begin
            if (!b[7]) begin
                bnd.res[0] = value_res({{(CpW-ByteW){1'b0}}, b}, r_sub);
                bnd.cnt    = 2'd1;
            end else if (len_b == LEN_NONE || i_beat.last) begin
                bnd.res[0] = subst_res(r_sub);
                bnd.cnt    = 2'd1;
            end else begin
                n_partial  = {{(CpW-ByteW){1'b0}}, b & (LEAD_MASK >> len_b)};
                n_needed   = len_b;
                n_held_cnt = '0;
            end
        end else begin
            n_partial = shifted;
            if ({1'b0, r_held_cnt} + LenW'(2) >= r_needed) begin
                bnd.res[0] = value_res(shifted, r_sub);
                bnd.cnt    = 2'd1;
                n_needed   = LEN_NONE;
                n_held_cnt = '0;
            end else if (i_beat.last) begin
                // Cut short: the lead is replaced and what followed it is decoded anew.
                bnd.res[0] = subst_res(r_sub);
                if (r_held_cnt == '0) begin
                    bnd.res[1] = single_res(b, r_sub);
                    bnd.cnt    = 2'd2;
                end else if (!r_held0[7]) begin
                    bnd.res[1] = value_res({{(CpW-ByteW){1'b0}}, r_held0}, r_sub);
                    bnd.res[2] = single_res(b, r_sub);
                    bnd.cnt    = 2'd3;
                end else if (len_h == LEN_2) begin
                    bnd.res[1] = value_res(CpW'({r_held0[4:0], b[TAIL_BITS-1:0]}), r_sub);
                    bnd.cnt    = 2'd2;
                end else begin
                    bnd.res[1] = subst_res(r_sub);
                    bnd.res[2] = single_res(b, r_sub);
                    bnd.cnt    = 2'd3;
                end
            end else begin
                // Only the first held byte is ever read back on a truncated end.
                if (r_held_cnt == '0) begin
                    n_held0 = b;
                end
                n_held_cnt = r_held_cnt + 2'd1;
            end
        end

        any_repl = bnd.res[0].repl || bnd.res[1].repl || bnd.res[2].repl;
        any_eqs  = bnd.res[0].eqs  || bnd.res[1].eqs  || bnd.res[2].eqs;

        n_sticky_srv = r_sticky_srv || any_repl;
        n_sticky_cli = r_sticky_cli || any_eqs;

        if (i_beat.last) begin
            for (int i = 0; i < MaxRes; i++) begin
                if (CntW'(i + 1) == bnd.cnt) begin
                    bnd.res[i].last = 1'b1;
                    bnd.res[i].srv  = n_sticky_srv;
                    bnd.res[i].cli  = n_sticky_cli;
                end
            end
            n_sticky_srv = 1'b0;
            n_sticky_cli = 1'b0;
            n_needed     = LEN_NONE;
            n_held_cnt   = '0;
            n_partial    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub        <= SUB_RESET;
            r_needed     <= LEN_NONE;
            r_held_cnt   <= '0;
            r_partial    <= '0;
            r_sticky_srv <= 1'b0;
            r_sticky_cli <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_sub <= i_cfg_data;
            end
            if (fire) begin
                r_needed     <= n_needed;
                r_held_cnt   <= n_held_cnt;
                r_partial    <= n_partial;
                r_sticky_srv <= n_sticky_srv;
                r_sticky_cli <= n_sticky_cli;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_held0 <= n_held0;
        end
    end

    assign o_bundle = bnd;

endmodule

[hdl/utf8d_out_seq.sv]
// Result register that holds a bundle of up to three results and sends them one per beat.
`timescale 1ns / 1ps

module utf8d_out_seq
    import utf8d_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_bundle  i_bundle,
    output logic     o_take,
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_res
);

    logic                 r_valid_unused;
    logic [CntW-1:0]      r_cnt;
    t_result [MaxRes-1:0] r_res;
    logic [CntW-1:0]      n_cnt;
    logic                 load;
    logic                 beat;

    assign o_valid = (r_cnt != '0);
    assign beat    = o_valid && i_ready;
    // A new bundle may enter when the register is empty or its last result leaves now.
    assign o_take  = (r_cnt == '0) || (r_cnt == 2'd1 && i_ready);
    assign load    = i_valid && o_take;

    always_comb begin
        n_cnt = r_cnt;
        if (load) begin
            n_cnt = i_bundle.cnt;
        end else if (beat) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt          <= '0;
            r_valid_unused <= 1'b0;
        end else begin
            r_cnt          <= n_cnt;
            r_valid_unused <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_bundle.res;
        end else if (beat) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    assign o_res = r_valid_unused ? '0 : r_res[0];

endmodule

[hdl/utf8_to_codepoint_decoder.sv]
// Top level of the streaming UTF-8 to code point decoder.
`timescale 1ns / 1ps

// Accepts one UTF-8 byte per beat on the slave stream (tlast marks the final byte of a
// string) and gives code points on the master stream, one per beat, in order. A byte is
// taken every cycle while the output keeps up; a byte that completes or passes a code
// point, or is replaced, gives one result, a byte inside a multibyte sequence gives none.
// When a string ends inside a sequence, that final byte gives two or three results; the
// result register sends them one per cycle while the output is ready, so the byte after it
// waits in the input register until the last of them leaves. A byte passes through the input
// register and the result register. Both input channels are held off during reset. The user
// must write the substitute code on the configuration channel only while the block is idle;
// the block does not enforce this. It resets to U+FFFD. String flags are valid only on tlast.
module utf8_to_codepoint_decoder
    import utf8d_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [CpW-1:0] i_cfg_data,    // substitute_code
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [7:0]     s_axis_tdata,  // [7:0] in_byte
    input  logic           s_axis_tlast,  // end_of_input
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [23:0]    m_axis_tdata,  // [20:0] code_point, [23:21] zero
    output logic [3:0]     m_axis_tuser,  // [0] was_replaced, [1] equals_substitute,
                                          // [2] string_server_flag, [3] string_client_flag
    output logic           m_axis_tlast   // last_of_string
);

    t_in_beat beat_q;
    t_bundle  bundle;
    t_result  res;
    logic     take;

    utf8d_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_take  (take),
        .o_beat  (beat_q)
    );

    utf8d_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_beat      (beat_q),
        .i_take      (take),
        .o_bundle    (bundle)
    );

    utf8d_out_seq u_out_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (beat_q.valid),
        .i_bundle (bundle),
        .o_take   (take),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_res    (res)
    );

    assign m_axis_tdata = {3'b000, res.cp};
    assign m_axis_tuser = {res.cli, res.srv, res.eqs, res.repl};
    assign m_axis_tlast = res.last;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the UTF-8 to code point decoder stream block.
`timescale 1ns / 1ps

module tb_top;
    import utf8d_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_GAP    = 6;
    localparam int HOLD_AT     = 80;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 30;

    typedef struct packed {
        logic [CpW-1:0] cp;
        logic           repl;
        logic           eqs;
        logic           last;
        logic           srv;
        logic           cli;
    } t_point_beat;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       wait_drain;
    } t_byte_item;

    typedef logic [7:0] t_byte_list [$];

    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_TOGGLE} t_sink_mode;

    logic           i_clk         = 1'b0;
    logic           i_rst_n       = 1'b0;
    logic           i_cfg_valid   = 1'b0;
    logic           o_cfg_ready;
    logic [CpW-1:0] i_cfg_data    = '0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [7:0]     s_axis_tdata  = '0;
    logic           s_axis_tlast  = 1'b0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [23:0]    m_axis_tdata;
    logic [3:0]     m_axis_tuser;
    logic           m_axis_tlast;

    utf8_to_codepoint_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decoder state mirrored by the predictor.
    logic [CpW-1:0]  subst_cp   = SUB_RESET;
    logic [2:0][7:0] tail_bytes = '0;
    int              tail_cnt   = 0;
    logic [LenW-1:0] seq_need   = LEN_NONE;
    logic [CpW-1:0]  acc_point  = '0;
    logic            srv_sticky = 1'b0;
    logic            cli_sticky = 1'b0;

    t_point_beat step_points [$];
    t_point_beat pending_points [$];
    t_byte_item  byte_q [$];
    t_byte_list  str_build;

    int   bytes_queued = 0;
    int   bytes_taken  = 0;
    int   fail_count   = 0;
    int   cycle_count  = 0;
    logic byte_taken   = 1'b0;

    function automatic logic [LenW-1:0] lead_length(input logic [7:0] b);
        if (b >= 8'hC0 && b <= 8'hDF) return LEN_2;
        if (b >= 8'hE0 && b <= 8'hEF) return LEN_3;
        if (b >= 8'hF0 && b <= 8'hF7) return LEN_4;
        return LEN_NONE;
    endfunction

    function automatic void push_point(input logic [CpW-1:0] cp, input logic repl,
                                       input logic eqs);
        t_point_beat r;
        r      = '0;
        r.cp   = cp;
        r.repl = repl;
        r.eqs  = eqs;
        if (repl) srv_sticky = 1'b1;
        if (eqs) cli_sticky = 1'b1;
        step_points.push_back(r);
    endfunction

    function automatic void push_value(input logic [CpW-1:0] v);
        push_point(v, 1'b0, v == subst_cp);
    endfunction

    // Decodes a remainder that is known to be complete; a lead without room is replaced.
    function automatic void decode_remainder(input logic [2:0][7:0] seq, input int n);
        int              i;
        int              j;
        logic [LenW-1:0] len;
        logic [CpW-1:0]  v;
        i = 0;
        while (i < n && step_points.size() < MaxRes) begin
            if (seq[i] < 8'h80) begin
                push_value(CpW'(seq[i]));
                i++;
            end else begin
                len = lead_length(seq[i]);
                if (len != LEN_NONE && int'(len) <= n - i) begin
                    v = CpW'(seq[i] & (LEAD_MASK >> len));
                    for (j = 1; j < int'(len); j++) begin
                        v = (v << TAIL_BITS) | CpW'(seq[i + j] & TAIL_MASK);
                    end
                    push_value(v);
                    i += int'(len);
                end else begin
                    push_point(subst_cp, 1'b1, 1'b0);
                    i++;
                end
            end
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eos);
        logic [2:0][7:0] rest;
        logic [LenW-1:0] len;
        t_point_beat     r;
        step_points.delete();
        if (seq_need == LEN_NONE) begin
            len = lead_length(b);
            if (eos) begin
                decode_remainder({16'h0, b}, 1);
            end else if (b < 8'h80) begin
                push_value(CpW'(b));
            end else if (len == LEN_NONE) begin
                push_point(subst_cp, 1'b1, 1'b0);
            end else begin
                acc_point = CpW'(b & (LEAD_MASK >> len));
                seq_need  = len;
                tail_cnt  = 0;
            end
        end else begin
            acc_point = (acc_point << TAIL_BITS) | CpW'(b & TAIL_MASK);
            if (tail_cnt + 2 >= int'(seq_need)) begin
                push_value(acc_point);
                seq_need = LEN_NONE;
                tail_cnt = 0;
            end else if (eos) begin
                // Cut short: the lead is replaced and the held bytes are decoded again.
                rest           = tail_bytes;
                rest[tail_cnt] = b;
                push_point(subst_cp, 1'b1, 1'b0);
                decode_remainder(rest, tail_cnt + 1);
                seq_need = LEN_NONE;
                tail_cnt = 0;
            end else begin
                tail_bytes[tail_cnt] = b;
                tail_cnt++;
            end
        end
        if (eos) begin
            if (step_points.size() > 0) begin
                r      = step_points.pop_back();
                r.last = 1'b1;
                r.srv  = srv_sticky;
                r.cli  = cli_sticky;
                step_points.push_back(r);
            end
            srv_sticky = 1'b0;
            cli_sticky = 1'b0;
            seq_need   = LEN_NONE;
            tail_cnt   = 0;
            acc_point  = '0;
        end
        foreach (step_points[k]) pending_points.push_back(step_points[k]);
    endfunction

    task automatic check_field(input string name, input logic [CpW-1:0] want,
                               input logic [CpW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Results are checked before the byte of the same edge is predicted.
    always @(posedge i_clk) begin : stream_monitor
        t_point_beat want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_points.size() == 0) begin
                    $error("code point beat with none expected: %0h", m_axis_tdata[CpW-1:0]);
                    fail_count++;
                end else begin
                    want = pending_points.pop_front();
                    check_field("code_point", want.cp, m_axis_tdata[CpW-1:0]);
                    check_field("was_replaced", CpW'(want.repl), CpW'(m_axis_tuser[0]));
                    check_field("equals_substitute", CpW'(want.eqs), CpW'(m_axis_tuser[1]));
                    check_field("last_of_string", CpW'(want.last), CpW'(m_axis_tlast));
                    check_field("string_server_flag", CpW'(want.srv), CpW'(m_axis_tuser[2]));
                    check_field("string_client_flag", CpW'(want.cli), CpW'(m_axis_tuser[3]));
                end
            end
            byte_taken = s_axis_tvalid && s_axis_tready;
            if (byte_taken) begin
                decode_byte(s_axis_tdata, s_axis_tlast);
                bytes_taken++;
            end
        end
    end

    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin : byte_driver
        t_byte_item it;
        logic       nv;
        logic [7:0] nd;
        logic       nl;
        nv = s_axis_tvalid;
        nd = s_axis_tdata;
        nl = s_axis_tlast;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!s_axis_tvalid || byte_taken) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (byte_q.size() > 0 &&
                         !(byte_q[0].wait_drain && pending_points.size() != 0)) begin
                it = byte_q.pop_front();
                nv = 1'b1;
                nd = it.data;
                nl = it.last;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata  <= nd;
        s_axis_tlast  <= nl;
    end

    t_sink_mode sink_mode = SINK_OPEN;
    int         mode_left = 0;
    int         hold_left = 0;
    logic       hold_done = 1'b0;

    always @(negedge i_clk) begin : sink_pacer
        logic rdy;
        if (mode_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
        end else begin
            mode_left--;
        end
        // One long stall while the sender keeps offering, so the input backs up.
        if (!hold_done && bytes_taken >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        case (sink_mode)
            SINK_OPEN:   rdy = 1'b1;
            SINK_COIN:   rdy = 1'($urandom_range(0, 1));
            SINK_SPARSE: rdy = ($urandom_range(0, 3) == 0);
            default:     rdy = ~m_axis_tready;
        endcase
        if (hold_left > 0) begin
            rdy = 1'b0;
            hold_left--;
        end
        m_axis_tready <= rdy;
    end

    task automatic queue_string(input logic wait_drain);
        t_byte_item it;
        foreach (str_build[i]) begin
            it.data       = str_build[i];
            it.last       = (i == str_build.size() - 1);
            it.wait_drain = wait_drain && (i == 0);
            byte_q.push_back(it);
            bytes_queued++;
        end
        str_build.delete();
    endtask

    function automatic logic [7:0] tail_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    task automatic add_char(input logic [CpW-1:0] sub);
        int kind;
        int len;
        int tails;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            str_build.push_back(8'($urandom_range(0, 127)));
        end else if (kind < 45) begin
            str_build.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            str_build.push_back(tail_byte());
        end else if (kind < 60) begin
            str_build.push_back(8'hE0 | 8'($urandom_range(0, 15)));
            repeat (2) str_build.push_back(tail_byte());
        end else if (kind < 70) begin
            str_build.push_back(8'hF0 | 8'($urandom_range(0, 7)));
            repeat (3) str_build.push_back(tail_byte());
        end else if (kind < 78) begin
            // The substitute value itself, encoded so that it decodes back to it.
            if (sub < 21'h80) begin
                str_build.push_back(sub[7:0]);
            end else if (sub < 21'h800) begin
                str_build.push_back({3'b110, sub[10:6]});
                str_build.push_back({2'b10, sub[5:0]});
            end else if (sub < 21'h10000) begin
                str_build.push_back({4'b1110, sub[15:12]});
                str_build.push_back({2'b10, sub[11:6]});
                str_build.push_back({2'b10, sub[5:0]});
            end else begin
                str_build.push_back({5'b11110, sub[20:18]});
                str_build.push_back({2'b10, sub[17:12]});
                str_build.push_back({2'b10, sub[11:6]});
                str_build.push_back({2'b10, sub[5:0]});
            end
        end else if (kind < 90) begin
            str_build.push_back(8'($urandom_range(0, 255)));
        end else begin
            len   = $urandom_range(2, 4);
            tails = $urandom_range(0, len - 2);
            case (len)
                2:       str_build.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                3:       str_build.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                default: str_build.push_back(8'hF0 | 8'($urandom_range(0, 7)));
            endcase
            repeat (tails) str_build.push_back(tail_byte());
        end
    endtask

    task automatic queue_random_bytes(input int n_bytes, input logic [CpW-1:0] sub,
                                      input int pause_at);
        int target;
        int str_idx;
        target  = bytes_queued + n_bytes;
        str_idx = 0;
        // Strings go on until the byte count is reached and the pausing string is queued.
        while (bytes_queued < target || str_idx <= pause_at) begin
            repeat ($urandom_range(1, 10)) add_char(sub);
            queue_string(str_idx == pause_at);
            str_idx++;
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (bytes_taken != bytes_queued || pending_points.size() != 0);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    task automatic write_substitute(input logic [CpW-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        subst_cp = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CpW-1:0] settings [5];
        settings[0] = 21'h1FFFFF;
        settings[1] = 21'h000000;
        settings[2] = CpW'($urandom_range(0, 21'h1FFFFF));
        settings[3] = 21'h000041;
        settings[4] = SUB_RESET;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Byte extremes, every sequence length, a decoded value equal to the reset substitute, a
        // stray continuation byte and undecodable leads, the last on the string's final byte.
        str_build = '{8'h00, 8'h7F, 8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBD,
                      8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80, 8'hF8, 8'hFF};
        queue_string(1'b0);
        // Sequences cut short by the end of the string, one with a second short lead.
        str_build = '{8'hE2, 8'h82};
        queue_string(1'b0);
        str_build = '{8'hF0, 8'h41, 8'h42};
        queue_string(1'b0);
        str_build = '{8'hF0, 8'hE2, 8'h82};
        queue_string(1'b0);
        str_build = '{8'hC3};
        queue_string(1'b0);
        str_build = '{8'h41};
        queue_string(1'b0);
        wait_idle();

        foreach (settings[p]) begin
            write_substitute(settings[p]);
            queue_random_bytes(PHASE_BYTES, settings[p], (p == 2) ? 2 : -1);
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/utf8d_pkg.sv
hdl/utf8d_in_reg.sv
hdl/utf8d_decode.sv
hdl/utf8d_out_seq.sv
hdl/utf8_to_codepoint_decoder.sv
tb/tb_top.sv
